FILE: design/adt_pkg.sv
// shared constants and result type for the audio dc tracking decimator
package adt_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int MODE_W       = 2;
  localparam int CENTER_W     = 16;
  localparam int DISP_W       = 13;
  localparam int MIN_W        = 8;

  localparam int GROUP_SIZE   = 32;
  localparam int BLOCK_SIZE   = 1024;
  localparam int WHOLE_GROUPS = BLOCK_SIZE / GROUP_SIZE;

  localparam int GROUP_SHIFT  = $clog2(GROUP_SIZE);
  localparam int WG_SHIFT     = $clog2(WHOLE_GROUPS);
  localparam int POS_W        = $clog2(BLOCK_SIZE);
  localparam int GSUM_W       = SAMPLE_W + GROUP_SHIFT;
  localparam int BSUM_W       = SAMPLE_W + WG_SHIFT;
  localparam int DIFF_W       = SAMPLE_W + 1;
  localparam int PT_W         = SAMPLE_W + 2;

  localparam logic [SAMPLE_W-1:0] DC_RESET    = SAMPLE_W'(2140);
  localparam logic [PT_W-1:0]     SCREEN_LIFT = PT_W'(90);
  localparam logic [MIN_W-1:0]    MIN_RESET   = MIN_W'(150);
  localparam logic [CENTER_W-1:0] RECORD_GAIN = CENTER_W'(10);

  localparam logic [MODE_W-1:0] MODE_DISPLAY = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_CENTER  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_RECORD  = MODE_W'(2);

  typedef struct packed {
    logic                       sample_valid;
    logic signed [CENTER_W-1:0] centered_sample;
    logic                       display_valid;
    logic [DISP_W-1:0]          display_value;
    logic                       block_end;
  } adt_result_t;

endpackage

FILE: design/adt_track.sv
// offset tracking state and per-sample datapath
module adt_track import adt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [MODE_W-1:0]   mode,
  output adt_result_t         result
);

  logic [SAMPLE_W-1:0] dc_offset;
  logic [GSUM_W-1:0]   group_sum;
  logic [BSUM_W-1:0]   block_avg_sum;
  logic [POS_W-1:0]    sample_position;
  logic [MIN_W-1:0]    running_minimum;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [CENTER_W-1:0] diff_wide;
  logic [GSUM_W-1:0]          group_total;
  logic [SAMPLE_W-1:0]        avg;
  logic signed [PT_W-1:0]     point;
  logic                       point_pos;
  logic [BSUM_W-1:0]          avg_total;
  logic [SAMPLE_W-1:0]        mean;
  logic [SAMPLE_W:0]          offset_sum;
  logic                       group_end;
  logic                       block_end;

  always_comb begin
    diff        = $signed({1'b0, sample}) - $signed({1'b0, dc_offset});
    diff_wide   = {{(CENTER_W - DIFF_W){diff[DIFF_W-1]}}, diff};
    group_total = group_sum + GSUM_W'(sample);
    avg         = group_total[GSUM_W-1:GROUP_SHIFT];
    point       = $signed(PT_W'(avg) + SCREEN_LIFT - PT_W'(dc_offset));
    point_pos   = (point > 0);
    avg_total   = block_avg_sum + BSUM_W'(avg);
    mean        = avg_total[BSUM_W-1:WG_SHIFT];
    offset_sum  = {1'b0, dc_offset} + {1'b0, mean};
    group_end   = &sample_position[GROUP_SHIFT-1:0];
    block_end   = (sample_position == POS_W'(BLOCK_SIZE - 1));
  end

  always_comb begin
    result = '0;
    case (mode)
      MODE_DISPLAY: begin
        result.sample_valid    = 1'b0;
        result.centered_sample = '0;
      end
      MODE_CENTER: begin
        result.sample_valid    = 1'b1;
        result.centered_sample = diff_wide;
      end
      default: begin
        // record mode, unused code treated the same
        result.sample_valid    = 1'b1;
        result.centered_sample = $signed(CENTER_W'($unsigned(diff_wide) * RECORD_GAIN));
      end
    endcase
    result.display_valid = group_end;
    if (group_end) begin
      result.display_value = point_pos ? point[DISP_W-1:0] : DISP_W'(running_minimum);
    end
    result.block_end = block_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_offset       <= DC_RESET;
      group_sum       <= '0;
      block_avg_sum   <= '0;
      sample_position <= '0;
      running_minimum <= MIN_RESET;
    end else if (step) begin
      if (block_end) begin
        dc_offset       <= offset_sum[SAMPLE_W:1];
        group_sum       <= '0;
        block_avg_sum   <= '0;
        sample_position <= '0;
        running_minimum <= MIN_RESET;
      end else begin
        sample_position <= sample_position + POS_W'(1);
        if (group_end) begin
          group_sum     <= '0;
          block_avg_sum <= avg_total;
          // point is below the minimum here, so it fits the minimum's width
          if (point_pos && (point < $signed(PT_W'(running_minimum)))) begin
            running_minimum <= point[MIN_W-1:0];
          end
        end else begin
          group_sum <= group_total;
        end
      end
    end
  end

endmodule

FILE: design/audio_dc_track_decimate.sv
// top level: dc tracking, centering and display decimation of adc samples
//
// input channel in_valid/in_ready carries one adc_sample per item; the output
// channel out_valid/out_ready returns exactly one result item per input item,
// in order. the config channel cfg_valid/cfg_ready writes capture_mode and is
// always ready; write it only while no item is in flight.
// an accepted item is held in the input register, then the tracking datapath
// writes the result register and out_valid is raised.
// throughput is one item per cycle while out_ready is high; both registers
// advance together, so a new item is taken while a finished result waits.
// every 32nd item carries a display point, every 1024th marks block end and
// the dc offset update, which applies from the next item on.
// when out_ready is low the result holds and the input register fills; after
// that in_ready drops until the receiver takes the result.
// reset empties both registers and restores offset 2140, minimum 150, empty
// accumulators and capture_mode 0 (display only).
module audio_dc_track_decimate import adt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [MODE_W-1:0]          capture_mode,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_W-1:0]        adc_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       sample_valid,
  output logic signed [CENTER_W-1:0] centered_sample,
  output logic                       display_valid,
  output logic [DISP_W-1:0]          display_value,
  output logic                       block_end
);

  logic [MODE_W-1:0]   mode;
  logic                in_full;
  logic [SAMPLE_W-1:0] sample_reg;
  logic                advance;
  adt_result_t         result;
  adt_result_t         result_reg;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DISPLAY;
    end else if (cfg_valid) begin
      mode <= capture_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_reg <= adc_sample;
    end
  end

  adt_track u_track (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (sample_reg),
    .mode   (mode),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign sample_valid    = result_reg.sample_valid;
  assign centered_sample = result_reg.centered_sample;
  assign display_valid   = result_reg.display_valid;
  assign display_value   = result_reg.display_value;
  assign block_end       = result_reg.block_end;

  a_block_on_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_end |-> display_valid)
    else $error("block end without display point");

  a_display_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_valid |-> display_value != '0)
    else $error("display point not positive");

  a_display_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !display_valid |-> display_value == '0)
    else $error("display value set without display point");

  a_display_only_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> centered_sample == '0)
    else $error("centered sample set in display only mode");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    in_full && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both registers are held");

endmodule
